### sv/pwl_pkg.sv
// Shared types and constants for the piecewise linear curve evaluator.
// No dependencies; imported by every design module of the block except the checker pwl_chk.
`timescale 1ns / 1ps

package pwl_pkg;

  localparam int MAX_KNOTS = 4;
  localparam int POS_W     = 16;
  localparam int FRAC_W    = 8;
  localparam int SEG_W     = 2;
  localparam int DIFF_W    = POS_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int NUM_W     = PROD_W;
  localparam int DEN_W     = DIFF_W;
  localparam int QUO_W     = POS_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [POS_W-1:0]  q88_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  localparam q88_t Q88_MAX = q88_t'(2 ** (POS_W - 1) - 1);
  localparam q88_t Q88_MIN = q88_t'(-(2 ** (POS_W - 1)));

  localparam q88_t KNOT_T_RST [MAX_KNOTS] = '{-16'sd256, 16'sd0, 16'sd256, 16'sd512};
  localparam q88_t KNOT_V_RST [MAX_KNOTS] = '{16'sd0, 16'sd0, 16'sd256, 16'sd512};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOT_T0,
    REG_KNOT_T1,
    REG_KNOT_T2,
    REG_KNOT_T3,
    REG_KNOT_V0,
    REG_KNOT_V1,
    REG_KNOT_V2,
    REG_KNOT_V3
  } cfg_reg_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic             zero;
    q88_t             v_left;
  } side_t;

  typedef struct packed {
    diff_t            dt;
    diff_t            dv;
    diff_t            dx;
    logic [SEG_W-1:0] seg;
    q88_t             v_left;
  } seg_res_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_val;
    logic [NUM_W-1:0] num_slp;
    logic             neg_val;
    logic             neg_slp;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] q_val;
    logic [QUO_W-1:0] q_slp;
    logic             ovf_val;
    logic             ovf_slp;
    logic             neg_val;
    logic             neg_slp;
    side_t            side;
  } div_res_t;

endpackage

### sv/piecewise_linear_spline_eval_unit.sv
// Piecewise linear curve evaluator, top level with knot registers.
// Requests pass the pwl_seg, pwl_prep, pwl_div and pwl_out registers; one request per cycle when not stalled.
// The 19-stage divider (overflow check, then 18 quotient bits) sets the depth;
// stalls collapse bubbles per stage.
// Synchronous reset empties the pipeline and loads the default knots.
// Depends on pwl_pkg, pwl_seg, pwl_prep, pwl_div, pwl_out.
`timescale 1ns / 1ps

module piecewise_linear_spline_eval_unit #(
  parameter int NUM_KNOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pwl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwl_pkg::POS_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pwl_pkg::POS_W-1:0]  sample_pos,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pwl_pkg::POS_W-1:0]  curve_value,
  output logic signed [pwl_pkg::POS_W-1:0]  curve_slope,
  output logic [pwl_pkg::SEG_W-1:0]         segment_index,
  output logic                              zero_width
);
  import pwl_pkg::*;

  q88_t     knot_t [MAX_KNOTS];
  q88_t     knot_v [MAX_KNOTS];

  logic     seg_ready, seg_valid;
  seg_res_t seg_res;
  logic     prep_ready, prep_valid;
  div_req_t div_req;
  logic     div_ready, div_valid;
  div_res_t div_res;
  logic     out_ready;
  logic     out_rdy_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_t <= KNOT_T_RST;
      knot_v <= KNOT_V_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KNOT_T0: knot_t[0] <= cfg_data;
        REG_KNOT_T1: knot_t[1] <= cfg_data;
        REG_KNOT_T2: knot_t[2] <= cfg_data;
        REG_KNOT_T3: knot_t[3] <= cfg_data;
        REG_KNOT_V0: knot_v[0] <= cfg_data;
        REG_KNOT_V1: knot_v[1] <= cfg_data;
        REG_KNOT_V2: knot_v[2] <= cfg_data;
        REG_KNOT_V3: knot_v[3] <= cfg_data;
      endcase
    end
  end

  assign in_stall  = !seg_ready;
  assign out_ready = !out_stall;

  pwl_seg #(
    .NUM_KNOTS (NUM_KNOTS)
  ) u_seg (
    .clk       (clk),
    .rst       (rst),
    .knot_t    (knot_t),
    .knot_v    (knot_v),
    .in_valid  (in_valid),
    .in_ready  (seg_ready),
    .pos       (sample_pos),
    .out_valid (seg_valid),
    .out_ready (prep_ready),
    .res       (seg_res)
  );

  pwl_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_valid),
    .in_ready  (prep_ready),
    .seg_in    (seg_res),
    .out_valid (prep_valid),
    .out_ready (div_ready),
    .req       (div_req)
  );

  pwl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (div_ready),
    .req       (div_req),
    .out_valid (div_valid),
    .out_ready (out_rdy_q),
    .res       (div_res)
  );

  pwl_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (out_rdy_q),
    .res       (div_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (curve_value),
    .slope     (curve_slope),
    .seg       (segment_index),
    .zero      (zero_width)
  );

endmodule

### sv/pwl_seg.sv
// Segment selection and knot differences, two pipeline stages.
// Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_seg #(
  parameter int NUM_KNOTS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  pwl_pkg::q88_t      knot_t [pwl_pkg::MAX_KNOTS],
  input  pwl_pkg::q88_t      knot_v [pwl_pkg::MAX_KNOTS],
  input  logic               in_valid,
  output logic               in_ready,
  input  pwl_pkg::q88_t      pos,
  output logic               out_valid,
  input  logic               out_ready,
  output pwl_pkg::seg_res_t  res
);
  import pwl_pkg::*;

  logic             found;
  logic [SEG_W-1:0] seg_pick;
  logic             v1, v2, rdy1, rdy2;
  q88_t             t1;
  logic [SEG_W-1:0] seg1, seg_r;
  q88_t             t_l, t_r, v_l, v_r;

  always_comb begin
    seg_pick = SEG_W'(NUM_KNOTS - 2);
    found    = 1'b0;
    for (int i = 1; i < NUM_KNOTS; i++) begin
      if (!found && pos <= knot_t[i]) begin
        seg_pick = SEG_W'(i - 1);
        found    = 1'b1;
      end
    end
    if (pos >= knot_t[NUM_KNOTS-1]) seg_pick = SEG_W'(NUM_KNOTS - 2);
    if (pos < knot_t[0]) seg_pick = '0;
  end

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      t1   <= pos;
      seg1 <= seg_pick;
    end
  end

  assign seg_r = seg1 + 1'b1;
  assign t_l   = knot_t[seg1];
  assign t_r   = knot_t[seg_r];
  assign v_l   = knot_v[seg1];
  assign v_r   = knot_v[seg_r];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      res.dt     <= diff_t'(t_r) - diff_t'(t_l);
      res.dv     <= diff_t'(v_r) - diff_t'(v_l);
      res.dx     <= diff_t'(t1) - diff_t'(t_l);
      res.seg    <= seg1;
      res.v_left <= v_l;
    end
  end

  assign out_valid = v2;

endmodule

### sv/pwl_prep.sv
// Numerator products and divider operand preparation, two pipeline stages.
// Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pwl_pkg::seg_res_t  seg_in,
  output logic               out_valid,
  input  logic               out_ready,
  output pwl_pkg::div_req_t  req
);
  import pwl_pkg::*;

  logic                     v3, v4, rdy3, rdy4;
  logic signed [PROD_W-1:0] prod_c, snum_c;
  logic signed [PROD_W-1:0] prod3, snum3;
  diff_t                    dt3;
  side_t                    side3;
  logic                     den_neg, val_neg, slp_neg;
  logic [DIFF_W-1:0]        d_mag;
  logic [NUM_W-1:0]         val_mag, slp_mag;

  assign prod_c = seg_in.dv * seg_in.dx;
  assign snum_c = PROD_W'(seg_in.dv) <<< FRAC_W;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      prod3        <= prod_c;
      snum3        <= snum_c;
      dt3          <= seg_in.dt;
      side3.seg    <= seg_in.seg;
      side3.zero   <= (seg_in.dt == '0);
      side3.v_left <= seg_in.v_left;
    end
  end

  // magnitudes; rounding offset folded in as 2n + d over 2d
  always_comb begin
    den_neg = dt3[DIFF_W-1];
    d_mag   = den_neg ? DIFF_W'(-dt3) : DIFF_W'(dt3);
    val_neg = prod3[PROD_W-1];
    slp_neg = snum3[PROD_W-1];
    val_mag = val_neg ? NUM_W'(-prod3) : NUM_W'(prod3);
    slp_mag = slp_neg ? NUM_W'(-snum3) : NUM_W'(snum3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      req.num_val <= {val_mag[NUM_W-2:0], 1'b0} + NUM_W'(d_mag);
      req.num_slp <= {slp_mag[NUM_W-2:0], 1'b0} + NUM_W'(d_mag);
      req.neg_val <= val_neg ^ den_neg;
      req.neg_slp <= slp_neg ^ den_neg;
      req.den     <= {d_mag[DEN_W-2:0], 1'b0};
      req.side    <= side3;
    end
  end

  assign out_valid = v4;

endmodule

### sv/pwl_div.sv
// Pipelined restoring divider for value and slope lanes sharing one divisor.
// One overflow stage, then one quotient bit per stage. Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pwl_pkg::div_req_t  req,
  output logic               out_valid,
  input  logic               out_ready,
  output pwl_pkg::div_res_t  res
);
  import pwl_pkg::*;

  localparam int NSTG = QUO_W + 1;

  typedef struct packed {
    logic [NUM_W-1:0] r_val;
    logic [NUM_W-1:0] r_slp;
    logic [QUO_W-1:0] q_val;
    logic [QUO_W-1:0] q_slp;
    logic             ovf_val;
    logic             ovf_slp;
    logic             neg_val;
    logic             neg_slp;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_stg_t;

  div_stg_t stg [NSTG];
  logic     vld [NSTG];
  logic     rdy [NSTG];
  logic     vin [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    div_stg_t nxt;

    if (j == 0) begin : g_head
      assign vin[j] = in_valid;
      always_comb begin
        nxt.r_val   = req.num_val;
        nxt.r_slp   = req.num_slp;
        nxt.q_val   = '0;
        nxt.q_slp   = '0;
        nxt.ovf_val = (req.num_val >> QUO_W) >= NUM_W'(req.den);
        nxt.ovf_slp = (req.num_slp >> QUO_W) >= NUM_W'(req.den);
        nxt.neg_val = req.neg_val;
        nxt.neg_slp = req.neg_slp;
        nxt.den     = req.den;
        nxt.side    = req.side;
      end
    end else begin : g_bit
      localparam int K = QUO_W - j;
      logic [NUM_W-1:0] dsh;
      assign vin[j] = vld[j-1];
      assign dsh    = NUM_W'(stg[j-1].den) << K;
      always_comb begin
        nxt = stg[j-1];
        if (stg[j-1].r_val >= dsh) begin
          nxt.r_val    = stg[j-1].r_val - dsh;
          nxt.q_val[K] = 1'b1;
        end
        if (stg[j-1].r_slp >= dsh) begin
          nxt.r_slp    = stg[j-1].r_slp - dsh;
          nxt.q_slp[K] = 1'b1;
        end
      end
    end

    if (j == NSTG - 1) begin : g_last
      assign rdy[j] = !vld[j] || out_ready;
    end else begin : g_mid
      assign rdy[j] = !vld[j] || rdy[j+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= vin[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && vin[j]) begin
        stg[j] <= nxt;
      end
    end
  end

  assign in_ready    = rdy[0];
  assign out_valid   = vld[NSTG-1];
  assign res.q_val   = stg[NSTG-1].q_val;
  assign res.q_slp   = stg[NSTG-1].q_slp;
  assign res.ovf_val = stg[NSTG-1].ovf_val;
  assign res.ovf_slp = stg[NSTG-1].ovf_slp;
  assign res.neg_val = stg[NSTG-1].neg_val;
  assign res.neg_slp = stg[NSTG-1].neg_slp;
  assign res.side    = stg[NSTG-1].side;

endmodule

### sv/pwl_out.sv
// Output stage: sign, intercept add, Q8.8 saturation and result register.
// Depends on pwl_pkg.
`timescale 1ns / 1ps

module pwl_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pwl_pkg::div_res_t             res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pwl_pkg::q88_t                 value,
  output pwl_pkg::q88_t                 slope,
  output logic [pwl_pkg::SEG_W-1:0]     seg,
  output logic                          zero
);
  import pwl_pkg::*;

  localparam int SQ_W  = QUO_W + 1;
  localparam int SUM_W = QUO_W + 2;

  logic                    vld, rdy;
  logic signed [SQ_W-1:0]  mag_val, mag_slp, sgn_val, sgn_slp;
  logic signed [SUM_W-1:0] sum;
  q88_t                    value_next, slope_next;

  assign mag_val = $signed({1'b0, res.q_val});
  assign mag_slp = $signed({1'b0, res.q_slp});
  assign sgn_val = res.neg_val ? -mag_val : mag_val;
  assign sgn_slp = res.neg_slp ? -mag_slp : mag_slp;
  assign sum     = SUM_W'(res.side.v_left) + SUM_W'(sgn_val);

  always_comb begin
    if (res.side.zero) begin
      value_next = '0;
    end else if (res.ovf_val) begin
      value_next = res.neg_val ? Q88_MIN : Q88_MAX;
    end else if (sum > SUM_W'(Q88_MAX)) begin
      value_next = Q88_MAX;
    end else if (sum < SUM_W'(Q88_MIN)) begin
      value_next = Q88_MIN;
    end else begin
      value_next = sum[POS_W-1:0];
    end

    if (res.side.zero) begin
      slope_next = '0;
    end else if (res.ovf_slp) begin
      slope_next = res.neg_slp ? Q88_MIN : Q88_MAX;
    end else if (sgn_slp > SQ_W'(Q88_MAX)) begin
      slope_next = Q88_MAX;
    end else if (sgn_slp < SQ_W'(Q88_MIN)) begin
      slope_next = Q88_MIN;
    end else begin
      slope_next = sgn_slp[POS_W-1:0];
    end
  end

  assign rdy      = !vld || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rdy) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      value <= value_next;
      slope <= slope_next;
      seg   <= res.side.seg;
      zero  <= res.side.zero;
    end
  end

  assign out_valid = vld;

endmodule

### sv/pwl_chk.sv
// Port-level checker for the curve evaluator, bound to the top level.
// Depends on piecewise_linear_spline_eval_unit.
`timescale 1ns / 1ps

module pwl_chk #(
  parameter int NUM_KNOTS = 4
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] curve_value,
  input logic signed [15:0] curve_slope,
  input logic [1:0]         segment_index,
  input logic               zero_width
);

  localparam logic [1:0] SEG_MAX = 2'(NUM_KNOTS - 2);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("request stalled while output side not blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(curve_value) && $stable(curve_slope))
    else $error("stalled result changed");

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_width |-> curve_value == '0 && curve_slope == '0)
    else $error("zero-width segment with nonzero value or slope");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segment_index <= SEG_MAX)
    else $error("segment index out of range");

endmodule

bind piecewise_linear_spline_eval_unit pwl_chk #(
  .NUM_KNOTS (NUM_KNOTS)
) u_pwl_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .curve_value   (curve_value),
  .curve_slope   (curve_slope),
  .segment_index (segment_index),
  .zero_width    (zero_width)
);

### test/piecewise_linear_spline_eval_unit_tb.sv
// Testbench for piecewise_linear_spline_eval_unit: drives sample positions and knot settings,
// and checks every result against a predicted curve value, slope, segment and zero-width flag.
// Depends on pwl_pkg and the piecewise_linear_spline_eval_unit RTL.
`timescale 1ns / 1ps

module piecewise_linear_spline_eval_unit_tb;
  import pwl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 115;
  localparam q88_t EDGE_POS [4] = '{Q88_MIN, -16'sd1, 16'sd0, Q88_MAX};

  typedef struct packed {
    q88_t             value;
    q88_t             slope;
    logic [SEG_W-1:0] seg;
    logic             zero;
  } curve_point_t;

  class curve_ledger;
    int           knot_pos [MAX_KNOTS];
    int           knot_val [MAX_KNOTS];
    curve_point_t pending_points [$];
    int unsigned  mismatches;

    function new();
      for (int k = 0; k < MAX_KNOTS; k++) begin
        knot_pos[k] = KNOT_T_RST[k];
        knot_val[k] = KNOT_V_RST[k];
      end
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, q88_t data);
      if (idx <= REG_KNOT_T3) begin
        knot_pos[idx - REG_KNOT_T0] = data;
      end else begin
        knot_val[idx - REG_KNOT_V0] = data;
      end
    endfunction

    // nearest, ties away from zero
    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      bit     neg;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      neg = (num < 0);
      mag = neg ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return neg ? -q : q;
    endfunction

    function q88_t clamp_q88(longint x);
      if (x > 32767) return Q88_MAX;
      if (x < -32768) return Q88_MIN;
      return q88_t'(x);
    endfunction

    function int choose_segment(int t);
      if (t < knot_pos[0]) return 0;
      if (t >= knot_pos[MAX_KNOTS-1]) return MAX_KNOTS - 2;
      for (int i = 1; i < MAX_KNOTS; i++) begin
        if (t <= knot_pos[i]) return i - 1;
      end
      return MAX_KNOTS - 2;
    endfunction

    function curve_point_t eval_curve(q88_t pos);
      curve_point_t r;
      int           t;
      int           s;
      longint       dt;
      longint       dv;
      longint       offs;
      t = pos;
      s = choose_segment(t);
      dt = longint'(knot_pos[s+1]) - longint'(knot_pos[s]);
      dv = longint'(knot_val[s+1]) - longint'(knot_val[s]);
      offs = longint'(t) - longint'(knot_pos[s]);
      r.seg = SEG_W'(s);
      if (dt == 0) begin
        r.value = '0;
        r.slope = '0;
        r.zero = 1'b1;
      end else begin
        r.zero = 1'b0;
        r.slope = clamp_q88(round_div(dv * 256, dt));
        r.value = clamp_q88(longint'(knot_val[s]) + round_div(dv * offs, dt));
      end
      return r;
    endfunction

    function void log_sample(q88_t pos);
      pending_points.push_back(eval_curve(pos));
    endfunction

    function int pending();
      return pending_points.size();
    endfunction

    function void match_result(q88_t value, q88_t slope, logic [SEG_W-1:0] seg, logic zero);
      curve_point_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result value %0d slope %0d seg %0d zero %0b",
                 $time, value, slope, seg, zero);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      if (value !== want.value) begin
        $display("%0t: curve_value expected %0d actual %0d", $time, want.value, value);
        mismatches++;
      end
      if (slope !== want.slope) begin
        $display("%0t: curve_slope expected %0d actual %0d", $time, want.slope, slope);
        mismatches++;
      end
      if (seg !== want.seg) begin
        $display("%0t: segment_index expected %0d actual %0d", $time, want.seg, seg);
        mismatches++;
      end
      if (zero !== want.zero) begin
        $display("%0t: zero_width expected %0b actual %0b", $time, want.zero, zero);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [POS_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  q88_t                 sample_pos;
  logic                 out_valid;
  logic                 out_stall;
  q88_t                 curve_value;
  q88_t                 curve_slope;
  logic [SEG_W-1:0]     segment_index;
  logic                 zero_width;

  curve_ledger ledger;
  q88_t        cur_pos [4];
  q88_t        cur_val [4];
  bit          idle_en;
  int unsigned cycle_count;

  piecewise_linear_spline_eval_unit #(.NUM_KNOTS(4)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_pos   (sample_pos),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .curve_value  (curve_value),
    .curve_slope  (curve_slope),
    .segment_index(segment_index),
    .zero_width   (zero_width)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      ledger.match_result(curve_value, curve_slope, segment_index, zero_width);
    end
  end

  // receiver stall bursts
  initial begin
    int stall_len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && !rst && $urandom_range(0, 5) == 0) begin
        stall_len = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pos(input q88_t pos);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_pos <= pos;
    do @(posedge clk); while (in_stall);
    ledger.log_sample(pos);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
  endtask

  task automatic program_curve();
    cfg_reg_t idx;
    for (int k = 0; k < 2 * MAX_KNOTS; k++) begin
      idx = cfg_reg_t'(k);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= (idx <= REG_KNOT_T3) ? cur_pos[idx - REG_KNOT_T0] : cur_val[idx - REG_KNOT_V0];
      @(negedge clk);
      ledger.set_reg(idx, (idx <= REG_KNOT_T3) ? cur_pos[idx - REG_KNOT_T0]
                                              : cur_val[idx - REG_KNOT_V0]);
    end
    cfg_write <= 1'b0;
  endtask

  // 0: sorted random, 1: sorted narrow with repeats, 2: unsorted, 3: extremes
  task automatic make_curve(input int mode);
    q88_t hold;
    int   step;
    for (int k = 0; k < 4; k++) begin
      cur_val[k] = $urandom_range(0, 1) ? q88_t'($urandom)
                                        : q88_t'($urandom_range(0, 2000) - 1000);
      case (mode)
        1: begin
          step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 600);
          cur_pos[k] = (k == 0) ? q88_t'($urandom_range(0, 4000) - 2000)
                                : q88_t'(cur_pos[k-1] + step);
        end
        3: begin
          cur_pos[k] = EDGE_POS[$urandom_range(0, 3)];
          cur_val[k] = EDGE_POS[$urandom_range(0, 3)];
        end
        default: cur_pos[k] = q88_t'($urandom);
      endcase
    end
    if (mode != 2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3 - i; j++) begin
          if (cur_pos[j] > cur_pos[j+1]) begin
            hold = cur_pos[j];
            cur_pos[j] = cur_pos[j+1];
            cur_pos[j+1] = hold;
          end
        end
      end
    end
  endtask

  function automatic q88_t rand_pos();
    int a;
    int b;
    int lo;
    int hi;
    a = $urandom_range(0, 3);
    b = $urandom_range(0, 3);
    lo = (cur_pos[a] < cur_pos[b]) ? cur_pos[a] : cur_pos[b];
    hi = (cur_pos[a] < cur_pos[b]) ? cur_pos[b] : cur_pos[a];
    case ($urandom_range(0, 3))
      0: return q88_t'($urandom);
      1: return q88_t'(lo + $urandom_range(0, 8) - 4);
      2: return q88_t'(lo + $urandom_range(0, hi - lo));
      default: return cur_pos[a];
    endcase
  endfunction

  initial begin
    ledger = new();
    cycle_count = 0;
    idle_en = 1'b1;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_KNOT_T0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_pos = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default knots: ends, knots, just beside knots
    send_pos(Q88_MIN);  send_pos(Q88_MAX);  send_pos(-16'sd257); send_pos(-16'sd256);
    send_pos(-16'sd255); send_pos(-16'sd1); send_pos(16'sd0);    send_pos(16'sd1);
    send_pos(16'sd255); send_pos(16'sd256); send_pos(16'sd511);  send_pos(16'sd512);

    // widest span with full swing values: saturation of value and slope
    wait_idle();
    cur_pos = '{Q88_MIN, -16'sd1, 16'sd0, Q88_MAX};
    cur_val = '{Q88_MAX, Q88_MIN, Q88_MAX, Q88_MIN};
    program_curve();
    send_pos(Q88_MIN);  send_pos(-16'sd2); send_pos(-16'sd1);
    send_pos(16'sd0);   send_pos(Q88_MAX); send_pos(16'sd16384);

    // zero-width end segments and a half-step tie in the middle
    wait_idle();
    cur_pos = '{16'sd0, 16'sd0, 16'sd2, 16'sd2};
    cur_val = '{16'sd9, 16'sd0, -16'sd1, 16'sd4};
    program_curve();
    send_pos(-16'sd1); send_pos(16'sd0); send_pos(16'sd1); send_pos(16'sd2);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      make_curve(ph % 4);
      program_curve();
      idle_en = (ph != RAND_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_idle();
        send_pos(rand_pos());
      end
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (ledger.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
